// ----- rtl/csfft_pkg.sv -----
// ----------------------------------------------------------------------------
// csfft_pkg
// Shared types, codes and constant tables of the centred, scaled complex FFT.
// ----------------------------------------------------------------------------
package csfft_pkg;

    localparam int MAX_LOG2_POINTS_DEF = 10;
    localparam int STORE_WIDTH_DEF     = 32;
    localparam int GUARD_BITS          = 4;
    localparam int L_W                 = 4;
    localparam int CFG_W               = 4;
    localparam int CFG_IDX_W           = 2;
    localparam logic [L_W-1:0] LOG2_RESET = 4'd10;

    localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;

    // 2^64/d rounded up, for the sine and cosine series denominators; exact
    // floor quotients for any dividend below 2^32
    localparam logic [127:0] RECIP_ONE = 128'd1 << 64;
    localparam logic [63:0] SIN_RECIP [8] = '{
        64'((RECIP_ONE + 128'd5) / 128'd6),
        64'((RECIP_ONE + 128'd19) / 128'd20),
        64'((RECIP_ONE + 128'd41) / 128'd42),
        64'((RECIP_ONE + 128'd71) / 128'd72),
        64'((RECIP_ONE + 128'd109) / 128'd110),
        64'((RECIP_ONE + 128'd155) / 128'd156),
        64'((RECIP_ONE + 128'd209) / 128'd210),
        64'((RECIP_ONE + 128'd271) / 128'd272)
    };
    localparam logic [63:0] COS_RECIP [8] = '{
        64'((RECIP_ONE + 128'd1) / 128'd2),
        64'((RECIP_ONE + 128'd11) / 128'd12),
        64'((RECIP_ONE + 128'd29) / 128'd30),
        64'((RECIP_ONE + 128'd55) / 128'd56),
        64'((RECIP_ONE + 128'd89) / 128'd90),
        64'((RECIP_ONE + 128'd131) / 128'd132),
        64'((RECIP_ONE + 128'd181) / 128'd182),
        64'((RECIP_ONE + 128'd239) / 128'd240)
    };

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    localparam logic [2:0] REV_LAST  = 3'd2;
    localparam logic [2:0] BFLY_LAST = 3'd4;
    localparam logic [2:0] SCALE_LAST = 3'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INVERSE = 2'd0,
        CFG_LOG2    = 2'd1,
        CFG_CENTRE  = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_REV,
        ST_BFLY,
        ST_SCALE
    } state_t;

    typedef enum logic [2:0] {
        WR_LOAD,
        WR_SWAP_B,
        WR_SWAP_A,
        WR_DIFF,
        WR_SUM,
        WR_SCALE
    } wr_sel_t;

    typedef struct packed {
        logic                func;
        logic signed [15:0]  sample_re;
        logic signed [15:0]  sample_im;
    } item_t;

    typedef struct packed {
        logic signed [15:0]  out_re;
        logic signed [15:0]  out_im;
        logic                last;
        logic                saturated;
        logic                status;
    } result_t;

    typedef struct packed {
        logic    wr_en;
        wr_sel_t wr_sel;
        logic    neg;
        logic    t_en;
        logic    out_take;
        logic    out_empty;
        logic    last;
    } dp_cmd_t;

    // round(32768 / sqrt(2^L)), 1.0 clipped
    localparam logic [15:0] INV_SQRT_Q15 [16] = '{
        16'd32767, 16'd23170, 16'd16384, 16'd11585, 16'd8192, 16'd5793, 16'd4096,
        16'd2896, 16'd2048, 16'd1448, 16'd1024, 16'd724, 16'd512, 16'd362,
        16'd256, 16'd181
    };

    function automatic logic [15:0] q15_of_q30(input longint v);
        longint t;
        t = (v < 0) ? 64'sd0 : v;
        t = (t + 64'sd16384) >>> 15;
        if (t > 64'sd32767)
        begin
            t = 64'sd32767;
        end
        return 16'(t);
    endfunction

    // {cos, sin} of twiddle k in a table of 2^max_log points, Q1.15
    function automatic logic [31:0] twiddle_entry(input int unsigned k,
                                                  input int unsigned max_log);
        int unsigned       quarter;
        int unsigned       q;
        int unsigned       r;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   t;
        longint            ss;
        longint            cc;
        logic [15:0]       s0;
        logic [15:0]       c0;
        quarter = 32'd1 << (max_log - 2);
        q  = k >> (max_log - 2);
        r  = k & (quarter - 1);
        x  = (longint'(r) * TWO_PI_Q30) >> max_log;
        x2 = (x * x) >> 30;
        t  = x;
        ss = longint'(x);
        for (int kk = 1; kk <= 8; kk++)
        begin
            t = 64'((128'((t * x2) >> 30) * 128'(SIN_RECIP[kk - 1])) >> 64);
            if ((kk & 1) == 1)
            begin
                ss = ss - longint'(t);
            end
            else
            begin
                ss = ss + longint'(t);
            end
        end
        t  = 64'd1 << 30;
        cc = longint'(t);
        for (int kk = 1; kk <= 8; kk++)
        begin
            t = 64'((128'((t * x2) >> 30) * 128'(COS_RECIP[kk - 1])) >> 64);
            if ((kk & 1) == 1)
            begin
                cc = cc - longint'(t);
            end
            else
            begin
                cc = cc + longint'(t);
            end
        end
        s0 = q15_of_q30(ss);
        c0 = q15_of_q30(cc);
        if (q == 0)
        begin
            return {c0, s0};
        end
        return {16'd0 - s0, c0};
    endfunction

endpackage

// ----- rtl/centred_scaled_complex_fft_top.sv -----
// ----------------------------------------------------------------------------
// centred_scaled_complex_fft_top
// Line-buffered radix-2 complex FFT with 1/sqrt(N) scaling and centring.
// ----------------------------------------------------------------------------
// Usage:
//   Input transaction: start high while busy is low. item.func selects load
//   (store the next sample) or read (return the next transformed element).
//   Configuration: cfg_we with cfg_index/cfg_data, taken at once; the user
//   must write it only while the block is idle, the block does not enforce it.
//   Results: strobe marks result for exactly one cycle; the receiver cannot
//   stall, so every result must be taken when shown.
// Sequence:
//   The load that completes a line of N = 2^L points starts the transform,
//   during which busy is high: a bit-reversal pass over every point, then the
//   butterfly passes (one shared butterfly unit on a store with two read
//   ports and one write port), then a scaling pass over every point.
//   A read is accepted while idle and passes through the read state (busy
//   high) before its registered result is shown; a read with no line ready
//   returns status 1 in the next cycle.
// Reset clears counters and the ready flag; the sample store is not cleared.
// ----------------------------------------------------------------------------
module centred_scaled_complex_fft_top
    import csfft_pkg::*;
#(
    parameter int MAX_LOG2_POINTS = MAX_LOG2_POINTS_DEF,
    parameter int STORE_WIDTH     = STORE_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  item_t                 item,
    output logic                  strobe,
    output result_t               result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    logic                          inverse_reg;
    logic [L_W-1:0]                log2_reg;
    logic                          centre_reg;
    dp_cmd_t                       cmd;
    logic [MAX_LOG2_POINTS-1:0]    addr_a, addr_b, wr_addr;
    logic [MAX_LOG2_POINTS-2:0]    tw_addr;
    logic [L_W-1:0]                scale_l;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inverse_reg <= 1'b0;
            log2_reg    <= LOG2_RESET;
            centre_reg  <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_INVERSE:
                begin
                    inverse_reg <= cfg_data[0];
                end
                CFG_LOG2:
                begin
                    log2_reg <= cfg_data[L_W-1:0];
                end
                CFG_CENTRE:
                begin
                    centre_reg <= cfg_data[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    csfft_ctrl #(
        .MAX_LOG2_POINTS (MAX_LOG2_POINTS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .func          (item.func),
        .log2_points   (log2_reg),
        .centre_enable (centre_reg),
        .busy          (busy),
        .cmd           (cmd),
        .addr_a        (addr_a),
        .addr_b        (addr_b),
        .wr_addr       (wr_addr),
        .tw_addr       (tw_addr),
        .scale_l       (scale_l)
    );

    csfft_dp #(
        .MAX_LOG2_POINTS (MAX_LOG2_POINTS),
        .STORE_WIDTH     (STORE_WIDTH)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .addr_a  (addr_a),
        .addr_b  (addr_b),
        .wr_addr (wr_addr),
        .tw_addr (tw_addr),
        .scale_l (scale_l),
        .inverse (inverse_reg),
        .item    (item),
        .result  (result),
        .strobe  (strobe)
    );

endmodule

// ----- rtl/csfft_dp.sv -----
// ----------------------------------------------------------------------------
// csfft_dp
// Sample store, twiddle ROM, butterfly and scaling arithmetic, result register.
// ----------------------------------------------------------------------------
module csfft_dp
    import csfft_pkg::*;
#(
    parameter int MAX_LOG2_POINTS = MAX_LOG2_POINTS_DEF,
    parameter int STORE_WIDTH     = STORE_WIDTH_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  dp_cmd_t                      cmd,
    input  logic [MAX_LOG2_POINTS-1:0]   addr_a,
    input  logic [MAX_LOG2_POINTS-1:0]   addr_b,
    input  logic [MAX_LOG2_POINTS-1:0]   wr_addr,
    input  logic [MAX_LOG2_POINTS-2:0]   tw_addr,
    input  logic [L_W-1:0]               scale_l,
    input  logic                         inverse,
    input  item_t                        item,
    output result_t                      result,
    output logic                         strobe
);

    localparam int SW     = STORE_WIDTH;
    localparam int POINTS = 1 << MAX_LOG2_POINTS;
    localparam int HALF   = POINTS / 2;
    localparam int PW     = SW + 17;

    localparam logic signed [PW:0] HALF15 = (PW+1)'(16384);
    localparam logic signed [SW:0] HALF4  = (SW+1)'(1 << (GUARD_BITS - 1));

    typedef logic [31:0] tw_rom_t [HALF];

    function automatic tw_rom_t build_tw();
        tw_rom_t rom;
        for (int k = 0; k < HALF; k++)
        begin
            rom[k] = twiddle_entry(k, MAX_LOG2_POINTS);
        end
        return rom;
    endfunction

    localparam tw_rom_t TW_ROM = build_tw();

    function automatic logic signed [SW-1:0] sat_sw(input logic signed [SW+3:0] v);
        if ((&v[SW+3:SW-1]) || !(|v[SW+3:SW-1]))
        begin
            return v[SW-1:0];
        end
        return v[SW+3] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    endfunction

    function automatic logic signed [SW-1:0] neg_sw(input logic signed [SW-1:0] x);
        return sat_sw(-((SW+4)'(x)));
    endfunction

    logic [2*SW-1:0]        store_mem [POINTS];
    logic [2*SW-1:0]        q_a_reg;
    logic [2*SW-1:0]        q_b_reg;
    logic [31:0]            tw_word_reg;
    logic [2*SW-1:0]        wr_data;

    logic signed [SW-1:0]   qa_re, qa_im, qb_re, qb_im;
    logic signed [SW-1:0]   a_re_reg, a_im_reg;
    logic signed [SW-1:0]   a2_re_reg, a2_im_reg;
    logic signed [16:0]     coef_c, coef_s, coef_f;
    logic signed [PW-1:0]   p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [PW-1:0]   sc_re_reg, sc_im_reg;
    logic signed [PW:0]     acc_re, acc_im, sca_re, sca_im;
    logic signed [SW+1:0]   t_re_reg, t_im_reg;
    logic signed [SW-1:0]   sc_re, sc_im, ld_re, ld_im;
    logic signed [SW:0]     ro_re, ro_im;
    logic                   clip_re, clip_im;
    logic signed [15:0]     o_re, o_im;
    result_t                result_reg;
    logic                   strobe_reg;

    assign qa_re = $signed(q_a_reg[2*SW-1:SW]);
    assign qa_im = $signed(q_a_reg[SW-1:0]);
    assign qb_re = $signed(q_b_reg[2*SW-1:SW]);
    assign qb_im = $signed(q_b_reg[SW-1:0]);

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        q_a_reg     <= store_mem[addr_a];
        q_b_reg     <= store_mem[addr_b];
        tw_word_reg <= TW_ROM[tw_addr];
    end

    assign coef_c = 17'($signed(tw_word_reg[31:16]));
    assign coef_s = inverse ? -17'($signed(tw_word_reg[15:0]))
                            : 17'($signed(tw_word_reg[15:0]));
    assign coef_f = $signed({1'b0, INV_SQRT_Q15[scale_l]});

    // products and the first operand run freely; the rounded twiddle product
    // and its partner are held for the difference and sum writes
    always_ff @(posedge clk)
    begin
        p_rr_reg  <= coef_c * qb_re;
        p_ii_reg  <= coef_s * qb_im;
        p_ri_reg  <= coef_c * qb_im;
        p_ir_reg  <= coef_s * qb_re;
        sc_re_reg <= coef_f * qa_re;
        sc_im_reg <= coef_f * qa_im;
        a_re_reg  <= qa_re;
        a_im_reg  <= qa_im;
        if (cmd.t_en)
        begin
            t_re_reg  <= (SW+2)'(acc_re >>> 15);
            t_im_reg  <= (SW+2)'(acc_im >>> 15);
            a2_re_reg <= a_re_reg;
            a2_im_reg <= a_im_reg;
        end
    end

    assign acc_re = (PW+1)'(p_rr_reg) - (PW+1)'(p_ii_reg) + HALF15;
    assign acc_im = (PW+1)'(p_ri_reg) + (PW+1)'(p_ir_reg) + HALF15;
    assign sca_re = (PW+1)'(sc_re_reg) + HALF15;
    assign sca_im = (PW+1)'(sc_im_reg) + HALF15;
    assign sc_re  = sat_sw((SW+4)'(sca_re >>> 15));
    assign sc_im  = sat_sw((SW+4)'(sca_im >>> 15));
    assign ld_re  = SW'(item.sample_re) <<< GUARD_BITS;
    assign ld_im  = SW'(item.sample_im) <<< GUARD_BITS;

    always_comb
    begin
        case (cmd.wr_sel)
            WR_LOAD:
            begin
                wr_data = {ld_re, ld_im};
            end
            WR_SWAP_B:
            begin
                wr_data = cmd.neg ? {neg_sw(qb_re), neg_sw(qb_im)} : {qb_re, qb_im};
            end
            WR_SWAP_A:
            begin
                wr_data = cmd.neg ? {neg_sw(a_re_reg), neg_sw(a_im_reg)}
                                  : {a_re_reg, a_im_reg};
            end
            WR_DIFF:
            begin
                wr_data = {sat_sw((SW+4)'(a2_re_reg) - (SW+4)'(t_re_reg)),
                           sat_sw((SW+4)'(a2_im_reg) - (SW+4)'(t_im_reg))};
            end
            WR_SUM:
            begin
                wr_data = {sat_sw((SW+4)'(a2_re_reg) + (SW+4)'(t_re_reg)),
                           sat_sw((SW+4)'(a2_im_reg) + (SW+4)'(t_im_reg))};
            end
            WR_SCALE:
            begin
                wr_data = cmd.neg ? {neg_sw(sc_re), neg_sw(sc_im)} : {sc_re, sc_im};
            end
            default:
            begin
                wr_data = '0;
            end
        endcase
    end

    // drop the guard bits with rounding, then clip to Q1.15
    assign ro_re   = ((SW+1)'(qa_re) + HALF4) >>> GUARD_BITS;
    assign ro_im   = ((SW+1)'(qa_im) + HALF4) >>> GUARD_BITS;
    assign clip_re = !((&ro_re[SW:15]) || !(|ro_re[SW:15]));
    assign clip_im = !((&ro_im[SW:15]) || !(|ro_im[SW:15]));
    assign o_re    = clip_re ? (ro_re[SW] ? 16'sh8000 : 16'sh7fff) : ro_re[15:0];
    assign o_im    = clip_im ? (ro_im[SW] ? 16'sh8000 : 16'sh7fff) : ro_im[15:0];

    always_ff @(posedge clk)
    begin
        if (cmd.out_take)
        begin
            result_reg.out_re    <= o_re;
            result_reg.out_im    <= o_im;
            result_reg.last      <= cmd.last;
            result_reg.saturated <= clip_re | clip_im;
            result_reg.status    <= 1'b0;
        end
        else if (cmd.out_empty)
        begin
            result_reg.out_re    <= '0;
            result_reg.out_im    <= '0;
            result_reg.last      <= 1'b0;
            result_reg.saturated <= 1'b0;
            result_reg.status    <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= cmd.out_take | cmd.out_empty;
        end
    end

    assign result = result_reg;
    assign strobe = strobe_reg;

endmodule

// ----- rtl/csfft_ctrl.sv -----
// ----------------------------------------------------------------------------
// csfft_ctrl
// Sequencer: load and read counters, bit-reversal, butterfly and scaling passes.
// ----------------------------------------------------------------------------
module csfft_ctrl
    import csfft_pkg::*;
#(
    parameter int MAX_LOG2_POINTS = MAX_LOG2_POINTS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         func,
    input  logic [L_W-1:0]               log2_points,
    input  logic                         centre_enable,
    output logic                         busy,
    output dp_cmd_t                      cmd,
    output logic [MAX_LOG2_POINTS-1:0]   addr_a,
    output logic [MAX_LOG2_POINTS-1:0]   addr_b,
    output logic [MAX_LOG2_POINTS-1:0]   wr_addr,
    output logic [MAX_LOG2_POINTS-2:0]   tw_addr,
    output logic [L_W-1:0]               scale_l
);

    localparam int AW = MAX_LOG2_POINTS;

    state_t              state_reg, state_next;
    logic [2:0]          step_reg, step_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic [L_W-1:0]      stage_reg, stage_next;
    logic [L_W-1:0]      l_reg, l_next;
    logic                ready_reg, ready_next;
    logic [AW:0]         load_cnt_reg, load_cnt_next;
    logic [AW:0]         read_cnt_reg, read_cnt_next;

    logic [L_W-1:0]      l_live;
    logic [AW:0]         n_live, n_reg;
    logic                accept;
    logic [AW-1:0]       idx_last, bf_last;
    logic [AW-1:0]       rev_full, rev_idx;
    logic [AW-1:0]       low_mask, bf_i, bf_j;

    always_comb
    begin
        if (log2_points == '0)
        begin
            l_live = L_W'(1);
        end
        else if (log2_points > L_W'(AW))
        begin
            l_live = L_W'(AW);
        end
        else
        begin
            l_live = log2_points;
        end
    end

    assign n_live   = (AW+1)'(1) << l_live;
    assign n_reg    = (AW+1)'(1) << l_reg;
    assign idx_last = AW'(n_reg - (AW+1)'(1));
    assign bf_last  = AW'((n_reg >> 1) - (AW+1)'(1));
    assign busy     = (state_reg != ST_IDLE);
    assign accept   = start && !busy;
    assign scale_l  = l_reg;

    always_comb
    begin
        for (int b = 0; b < AW; b++)
        begin
            rev_full[b] = idx_reg[AW-1-b];
        end
    end

    assign rev_idx  = rev_full >> (L_W'(AW) - l_reg);
    assign low_mask = (AW'(1) << stage_reg) - AW'(1);
    assign bf_i     = ((idx_reg & ~low_mask) << 1) | (idx_reg & low_mask);
    assign bf_j     = bf_i | (AW'(1) << stage_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            step_reg     <= '0;
            idx_reg      <= '0;
            stage_reg    <= '0;
            l_reg        <= L_W'(1);
            ready_reg    <= 1'b0;
            load_cnt_reg <= '0;
            read_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            idx_reg      <= idx_next;
            stage_reg    <= stage_next;
            l_reg        <= l_next;
            ready_reg    <= ready_next;
            load_cnt_reg <= load_cnt_next;
            read_cnt_reg <= read_cnt_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        idx_next      = idx_reg;
        stage_next    = stage_reg;
        l_next        = l_reg;
        ready_next    = ready_reg;
        load_cnt_next = load_cnt_reg;
        read_cnt_next = read_cnt_reg;
        cmd           = '0;
        addr_a        = idx_reg;
        addr_b        = idx_reg;
        wr_addr       = idx_reg;
        tw_addr       = (AW-1)'((idx_reg & low_mask) << (L_W'(AW - 1) - stage_reg));

        unique case (state_reg)
            ST_IDLE:
            begin
                addr_a  = read_cnt_reg[AW-1:0];
                wr_addr = load_cnt_reg[AW-1:0];
                if (accept && (func == FUNC_LOAD))
                begin
                    cmd.wr_en     = 1'b1;
                    cmd.wr_sel    = WR_LOAD;
                    ready_next    = 1'b0;
                    read_cnt_next = '0;
                    if ((load_cnt_reg + (AW+1)'(1)) >= n_live)
                    begin
                        load_cnt_next = '0;
                        l_next        = l_live;
                        state_next    = ST_REV;
                        idx_next      = '0;
                        step_next     = '0;
                    end
                    else
                    begin
                        load_cnt_next = load_cnt_reg + (AW+1)'(1);
                    end
                end
                else if (accept && ready_reg)
                begin
                    state_next = ST_READ;
                end
                else if (accept)
                begin
                    cmd.out_empty = 1'b1;
                end
            end
            ST_READ:
            begin
                addr_a       = read_cnt_reg[AW-1:0];
                cmd.out_take = 1'b1;
                cmd.last     = (read_cnt_reg + (AW+1)'(1)) >= n_live;
                state_next   = ST_IDLE;
                if (cmd.last)
                begin
                    ready_next    = 1'b0;
                    read_cnt_next = '0;
                end
                else
                begin
                    read_cnt_next = read_cnt_reg + (AW+1)'(1);
                end
            end
            ST_REV:
            begin
                addr_b = rev_idx;
                // each pair is swapped once, from its lower index
                if (step_reg == 3'd1)
                begin
                    cmd.wr_en  = (rev_idx >= idx_reg);
                    cmd.wr_sel = WR_SWAP_B;
                    cmd.neg    = centre_enable & rev_idx[0];
                    wr_addr    = idx_reg;
                end
                else if (step_reg == REV_LAST)
                begin
                    cmd.wr_en  = (rev_idx > idx_reg);
                    cmd.wr_sel = WR_SWAP_A;
                    cmd.neg    = centre_enable & idx_reg[0];
                    wr_addr    = rev_idx;
                end
                if (step_reg == REV_LAST)
                begin
                    step_next = '0;
                    if (idx_reg == idx_last)
                    begin
                        idx_next   = '0;
                        stage_next = '0;
                        state_next = ST_BFLY;
                    end
                    else
                    begin
                        idx_next = idx_reg + AW'(1);
                    end
                end
                else
                begin
                    step_next = step_reg + 3'd1;
                end
            end
            ST_BFLY:
            begin
                addr_a = bf_i;
                addr_b = bf_j;
                if (step_reg == 3'd2)
                begin
                    cmd.t_en = 1'b1;
                end
                else if (step_reg == 3'd3)
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = WR_DIFF;
                    wr_addr    = bf_j;
                end
                else if (step_reg == BFLY_LAST)
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = WR_SUM;
                    wr_addr    = bf_i;
                end
                if (step_reg == BFLY_LAST)
                begin
                    step_next = '0;
                    if (idx_reg == bf_last)
                    begin
                        idx_next = '0;
                        if (stage_reg == (l_reg - L_W'(1)))
                        begin
                            state_next = ST_SCALE;
                        end
                        else
                        begin
                            stage_next = stage_reg + L_W'(1);
                        end
                    end
                    else
                    begin
                        idx_next = idx_reg + AW'(1);
                    end
                end
                else
                begin
                    step_next = step_reg + 3'd1;
                end
            end
            ST_SCALE:
            begin
                if (step_reg == SCALE_LAST)
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = WR_SCALE;
                    cmd.neg    = centre_enable & idx_reg[0];
                    step_next  = '0;
                    if (idx_reg == idx_last)
                    begin
                        idx_next      = '0;
                        ready_next    = 1'b1;
                        read_cnt_next = '0;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + AW'(1);
                    end
                end
                else
                begin
                    step_next = step_reg + 3'd1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/csfft_checker.sv -----
// ----------------------------------------------------------------------------
// csfft_checker
// Port-level checks of the FFT block, bound to the top level.
// ----------------------------------------------------------------------------
module csfft_checker
    import csfft_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  logic     busy,
    input  item_t    item,
    input  logic     strobe,
    input  result_t  result
);

    // results are only shown once the sequencer is back to idle
    a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> !busy)
        else $error("result shown while busy");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && result.status) |-> (result.out_re == 16'sd0) &&
            (result.out_im == 16'sd0) && !result.last && !result.saturated)
        else $error("empty result carries data");

    a_strobe_cause: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> ($past(busy) || $past(start && (item.func == FUNC_READ))))
        else $error("result without a read transaction");

    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (item.func == FUNC_LOAD)) |=> !strobe)
        else $error("load transaction produced a result");

endmodule

bind centred_scaled_complex_fft_top csfft_checker u_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .strobe (strobe),
    .result (result)
);
